// ===== rtl/core/rcsa_pkg.sv =====
package rcsa_pkg;

  // Field widths
  localparam int unsigned StickW   = 12;
  localparam int unsigned PatternW = 8;
  localparam int unsigned CountW   = 8;

  // Hold counter limits and disarm guard
  localparam logic [CountW-1:0] HoldMax     = 8'd250;
  localparam logic [CountW-1:0] HoldFire    = 8'd20;
  localparam logic [CountW-1:0] TicksMax    = 8'd255;
  localparam logic [CountW-1:0] DisarmGuard = 8'd3;

  // Stick combos
  localparam logic [PatternW-1:0] ComboGyro = 8'h57;
  localparam logic [PatternW-1:0] ComboArm  = 8'h6F;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_CHECK          = 2'd0,
    REG_MAX_CHECK          = 2'd1,
    REG_ARM_BY_STICKS      = 2'd2,
    REG_KILL_SWITCH_DISARM = 2'd3
  } rcsa_reg_e;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [StickW-1:0] min_check;
    logic [StickW-1:0] max_check;
    logic              arm_by_sticks;
    logic              kill_switch_disarm;
  } rcsa_cfg_t;

  // One classified frame handed to the arming controller
  typedef struct packed {
    logic [PatternW-1:0] pattern;
    logic                throttle_idle;
    logic                arm_switch_on;
    logic                arm_allowed;
    logic                signal_present;
  } rcsa_frame_t;

  // Arming status produced for one frame
  typedef struct packed {
    logic armed;
    logic arm_event;
    logic disarm_event;
    logic gyro_cal_request;
  } rcsa_status_t;

endpackage

// ===== rtl/core/rcsa_classify.sv =====
module rcsa_classify (
  input  logic [rcsa_pkg::StickW-1:0]   roll_value_i,
  input  logic [rcsa_pkg::StickW-1:0]   pitch_value_i,
  input  logic [rcsa_pkg::StickW-1:0]   yaw_value_i,
  input  logic [rcsa_pkg::StickW-1:0]   throttle_value_i,
  input  rcsa_pkg::rcsa_cfg_t           cfg_i,
  output logic [rcsa_pkg::PatternW-1:0] pattern_o,
  output logic                          throttle_idle_o
);

  logic [rcsa_pkg::StickW-1:0] values [4];

  assign values[0] = roll_value_i;
  assign values[1] = pitch_value_i;
  assign values[2] = yaw_value_i;
  assign values[3] = throttle_value_i;

  // Two bits per stick: above min_check, below max_check.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pattern_o[2*i+1] = values[i] > cfg_i.min_check;
      pattern_o[2*i]   = values[i] < cfg_i.max_check;
    end
  end

  assign throttle_idle_o = throttle_value_i < cfg_i.min_check;

endmodule

// ===== rtl/core/rcsa_arm_ctrl.sv =====
module rcsa_arm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  rcsa_pkg::rcsa_cfg_t    cfg_i,
  input  rcsa_pkg::rcsa_frame_t  frame_i,
  output rcsa_pkg::rcsa_status_t status_o
);

  logic [rcsa_pkg::PatternW-1:0] last_pattern_q, last_pattern_d;
  logic [rcsa_pkg::CountW-1:0]   hold_count_q, hold_count_d;
  logic [rcsa_pkg::CountW-1:0]   disarm_ticks_q, disarm_ticks_d;
  logic                          armed_q, armed_d;
  logic                          armed_sw;
  logic [rcsa_pkg::CountW-1:0]   ticks_inc;
  logic                          gyro;

  // Hold counter: counts frames with an unchanged pattern, saturating.
  always_comb begin
    if (frame_i.pattern == last_pattern_q) begin
      hold_count_d = (hold_count_q < rcsa_pkg::HoldMax) ?
                     hold_count_q + rcsa_pkg::CountW'(1) : hold_count_q;
    end else begin
      hold_count_d = '0;
    end
    last_pattern_d = frame_i.pattern;
  end

  // Switch arming and guarded switch disarming.
  always_comb begin
    ticks_inc      = (disarm_ticks_q < rcsa_pkg::TicksMax) ?
                     disarm_ticks_q + rcsa_pkg::CountW'(1) : disarm_ticks_q;
    disarm_ticks_d = disarm_ticks_q;
    armed_sw       = armed_q;
    if (!cfg_i.arm_by_sticks) begin
      if (frame_i.arm_switch_on) begin
        disarm_ticks_d = '0;
        if (frame_i.throttle_idle && frame_i.arm_allowed) begin
          armed_sw = 1'b1;
        end
      end else if (armed_q && frame_i.signal_present) begin
        disarm_ticks_d = ticks_inc;
        if (ticks_inc > rcsa_pkg::DisarmGuard &&
            (cfg_i.kill_switch_disarm || frame_i.throttle_idle)) begin
          armed_sw = 1'b0;
        end
      end
    end
  end

  // Stick combos fire once, on the frame the hold count reaches the mark.
  always_comb begin
    gyro    = 1'b0;
    armed_d = armed_sw;
    if (hold_count_d == rcsa_pkg::HoldFire && !armed_sw) begin
      if (frame_i.pattern == rcsa_pkg::ComboGyro) begin
        gyro = 1'b1;
      end else if (cfg_i.arm_by_sticks && frame_i.pattern == rcsa_pkg::ComboArm &&
                   frame_i.arm_allowed) begin
        armed_d = 1'b1;
      end
    end
  end

  always_comb begin
    status_o.armed            = armed_d;
    status_o.arm_event        = !armed_q && armed_d;
    status_o.disarm_event     = armed_q && !armed_d;
    status_o.gyro_cal_request = gyro;
  end

  // State advances only when a frame moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pattern_q <= '0;
      hold_count_q   <= '0;
      disarm_ticks_q <= '0;
      armed_q        <= 1'b0;
    end else if (step_i) begin
      last_pattern_q <= last_pattern_d;
      hold_count_q   <= hold_count_d;
      disarm_ticks_q <= disarm_ticks_d;
      armed_q        <= armed_d;
    end
  end

  // The hold counter never passes its ceiling.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_count_q <= rcsa_pkg::HoldMax)
    else $error("hold count above its ceiling");

  // A gyro calibration request is only raised while disarmed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && status_o.gyro_cal_request) |-> !status_o.armed)
    else $error("gyro request while armed");

  // Disarming only happens through the switch path.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && status_o.disarm_event) |-> !cfg_i.arm_by_sticks)
    else $error("disarm with stick arming selected");

  // The armed register follows the status of the frame just taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> armed_q == $past(status_o.armed))
    else $error("armed state lost a frame result");

endmodule

// ===== rtl/core/rc_stick_command_arming.sv =====
// RC stick command and arming handler. Each request carries one RC frame (four
// stick values and the arm switch, arm-permission and signal flags) and yields
// exactly one result: the 8-bit stick pattern, the throttle-idle flag, the armed
// flag and one-frame arm, disarm and gyro calibration flags. A frame waits in the
// input register and is classified and applied to the arming state on its way
// into the result register, so a new frame is taken every cycle while the
// result side keeps up. Configuration writes take effect at once and are
// meant to be made while no frame is in flight.
module rc_stick_command_arming (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [rcsa_pkg::StickW-1:0]   cfg_data_i,
  // Frame input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rcsa_pkg::StickW-1:0]   roll_value_i,
  input  logic [rcsa_pkg::StickW-1:0]   pitch_value_i,
  input  logic [rcsa_pkg::StickW-1:0]   yaw_value_i,
  input  logic [rcsa_pkg::StickW-1:0]   throttle_value_i,
  input  logic                          arm_switch_on_i,
  input  logic                          arm_allowed_i,
  input  logic                          signal_present_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rcsa_pkg::PatternW-1:0] stick_pattern_o,
  output logic                          throttle_idle_o,
  output logic                          armed_o,
  output logic                          arm_event_o,
  output logic                          disarm_event_o,
  output logic                          gyro_cal_request_o
);

  rcsa_pkg::rcsa_cfg_t           cfg_q;
  logic                          in_valid_q;
  logic [rcsa_pkg::StickW-1:0]   roll_q, pitch_q, yaw_q, throttle_q;
  logic                          sw_on_q, ok_arm_q, signal_q;
  logic                          out_valid_q;
  logic [rcsa_pkg::PatternW-1:0] pattern_q;
  logic                          thr_low_q;
  rcsa_pkg::rcsa_status_t        status_q;
  logic                          advance;
  logic                          take_in;
  logic [rcsa_pkg::PatternW-1:0] pattern;
  logic                          thr_low;
  rcsa_pkg::rcsa_frame_t         frame;
  rcsa_pkg::rcsa_status_t        status;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_check          <= 12'd1100;
      cfg_q.max_check          <= 12'd1900;
      cfg_q.arm_by_sticks      <= 1'b1;
      cfg_q.kill_switch_disarm <= 1'b0;
    end else if (cfg_we_i) begin
      case (rcsa_pkg::rcsa_reg_e'(cfg_index_i))
        rcsa_pkg::REG_MIN_CHECK:          cfg_q.min_check          <= cfg_data_i;
        rcsa_pkg::REG_MAX_CHECK:          cfg_q.max_check          <= cfg_data_i;
        rcsa_pkg::REG_ARM_BY_STICKS:      cfg_q.arm_by_sticks      <= cfg_data_i[0];
        rcsa_pkg::REG_KILL_SWITCH_DISARM: cfg_q.kill_switch_disarm <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: a frame moves on whenever the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign take_in    = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take_in) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      roll_q     <= roll_value_i;
      pitch_q    <= pitch_value_i;
      yaw_q      <= yaw_value_i;
      throttle_q <= throttle_value_i;
      sw_on_q    <= arm_switch_on_i;
      ok_arm_q   <= arm_allowed_i;
      signal_q   <= signal_present_i;
    end
  end

  rcsa_classify u_classify (
    .roll_value_i     (roll_q),
    .pitch_value_i    (pitch_q),
    .yaw_value_i      (yaw_q),
    .throttle_value_i (throttle_q),
    .cfg_i            (cfg_q),
    .pattern_o        (pattern),
    .throttle_idle_o  (thr_low)
  );

  always_comb begin
    frame.pattern        = pattern;
    frame.throttle_idle  = thr_low;
    frame.arm_switch_on  = sw_on_q;
    frame.arm_allowed    = ok_arm_q;
    frame.signal_present = signal_q;
  end

  rcsa_arm_ctrl u_arm_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .cfg_i    (cfg_q),
    .frame_i  (frame),
    .status_o (status)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pattern_q <= pattern;
      thr_low_q <= thr_low;
      status_q  <= status;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign stick_pattern_o    = pattern_q;
  assign throttle_idle_o    = thr_low_q;
  assign armed_o            = status_q.armed;
  assign arm_event_o        = status_q.arm_event;
  assign disarm_event_o     = status_q.disarm_event;
  assign gyro_cal_request_o = status_q.gyro_cal_request;

endmodule
